// ===== rtl/psrr_pkg.sv =====
// Package for the periodic sample ring recorder.
// Holds the item structs, opcode and register index codes, and field widths.
// Used by the top level and the checker; depends on nothing.
`default_nettype none

package psrr_pkg;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int TIME_W  = 32;
    localparam int PER_W   = 16;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 32;

    localparam logic [OP_W-1:0] OP_START  = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;

    localparam logic [MODE_W-1:0] EV_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] EV_BELOW = 2'd1;
    localparam logic [MODE_W-1:0] EV_EQUAL = 2'd2;
    localparam logic [MODE_W-1:0] EV_ABOVE = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MODE      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [VAL_W-1:0]  sample_value;
        logic [TIME_W-1:0]        start_time;
        logic [TIME_W-1:0]        query_time;
    } in_item_t;

    typedef struct packed {
        logic                     sample_stored;
        logic                     event_hit;
        logic                     found;
        logic [TIME_W-1:0]        result_time;
        logic signed [VAL_W-1:0]  result_value;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/psrr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; depends on nothing.
`default_nettype none

module psrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/periodic_sample_ring_recorder.sv =====
// Top level of the periodic sample ring recorder: sequencer, registers and two ring RAMs.
// Depends on psrr_pkg and psrr_ram.
//
// Usage: items enter on s_valid/s_ready with an in_item_t payload on s_data, and
// results leave on m_valid/m_ready as an out_item_t on m_data, one result per item.
// Configuration goes through cfg_we, cfg_index and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. A write takes
// effect at the clock edge and has no handshake. The block works on one item at a time
// and drops s_ready from acceptance until the result is moved into the output register.
// A tick whose phase must be reduced after the period was lowered goes through the
// bit-serial remainder unit. Lookup and next-larger queries walk the ring through the
// RAM read port, one entry per cycle, up to min(sample count, RING_DEPTH) entries;
// a lookup stops at its first match.
// The output register holds a result while the receiver stalls, and the next item
// is accepted meanwhile; it waits at its end until the register is free.
// Reset (aresetn low, synchronous) clears the configuration, recording state and
// handshakes. Ring contents are not cleared, and only written entries are read.
`default_nettype none

module periodic_sample_ring_recorder #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire psrr_pkg::in_item_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output psrr_pkg::out_item_t                 m_data,
    input  wire logic                           cfg_we,
    input  wire logic [psrr_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [psrr_pkg::CDATA_W-1:0]   cfg_wdata
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = psrr_pkg::PER_W;
    localparam int TW = psrr_pkg::TIME_W;
    localparam int VW = psrr_pkg::VAL_W;
    localparam int MOD_STEPS = PW + 1;
    localparam int MCW = $clog2(MOD_STEPS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_TREAD  = 3'd2;
    localparam logic [2:0] S_TWRITE = 3'd3;
    localparam logic [2:0] S_PHASE  = 3'd4;
    localparam logic [2:0] S_MOD    = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [PW-1:0]                period_reg, period_next;
    logic [psrr_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic signed [VW-1:0]         thresh_reg, thresh_next;
    logic                         recording_reg, recording_next;
    logic [PW-1:0]                phase_reg, phase_next;
    logic [AW-1:0]                slot_reg, slot_next;
    logic                         slot_valid_reg, slot_valid_next;
    logic [31:0]                  total_reg, total_next;
    logic [TW-1:0]                start_stamp_reg, start_stamp_next;
    logic                         m_valid_reg, m_valid_next;

    psrr_pkg::in_item_t           in_reg, in_next;
    psrr_pkg::out_item_t          out_reg, out_next;
    logic                         stored_reg, stored_next;
    logic                         hit_reg, hit_next;
    logic                         found_reg, found_next;
    logic [TW-1:0]                rtime_reg, rtime_next;
    logic signed [VW-1:0]         rvalue_reg, rvalue_next;
    logic [TW-1:0]                stamp_reg, stamp_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                issue_reg, issue_next;
    logic                         pend_reg, pend_next;
    logic [PW-1:0]                rem_reg, rem_next;
    logic [PW:0]                  dvd_reg, dvd_next;
    logic [MCW-1:0]               step_reg, step_next;

    logic [PW-1:0]                eff_period;
    logic [PW:0]                  phase_sum;
    logic [PW:0]                  trial;
    logic [PW:0]                  trial_sub;
    logic                         issue_ok;
    logic                         ev_hit;
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [TW-1:0]                stamp_rdata;
    logic [VW-1:0]                value_rdata;

    assign eff_period = (period_reg == '0) ? PW'(1) : period_reg;
    assign phase_sum  = {1'b0, phase_reg} + (PW+1)'(1);
    assign trial      = {rem_reg, dvd_reg[PW]};
    assign trial_sub  = trial - {1'b0, eff_period};
    assign issue_ok   = issue_reg != count_reg;
    assign ram_we     = state_reg == S_TWRITE;
    assign ram_raddr  = (state_reg == S_SCAN) ? issue_reg[AW-1:0] : slot_reg;

    always_comb begin
        case (mode_reg)
            psrr_pkg::EV_BELOW: ev_hit = s_data.sample_value < thresh_reg;
            psrr_pkg::EV_EQUAL: ev_hit = s_data.sample_value == thresh_reg;
            psrr_pkg::EV_ABOVE: ev_hit = s_data.sample_value > thresh_reg;
            default:            ev_hit = 1'b0;
        endcase
    end

    psrr_ram #(.WIDTH(TW), .DEPTH(RING_DEPTH)) u_stamp_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (stamp_reg),
        .raddr (ram_raddr),
        .rdata (stamp_rdata)
    );

    psrr_ram #(.WIDTH(VW), .DEPTH(RING_DEPTH)) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (in_reg.sample_value),
        .raddr (ram_raddr),
        .rdata (value_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        period_next      = period_reg;
        mode_next        = mode_reg;
        thresh_next      = thresh_reg;
        recording_next   = recording_reg;
        phase_next       = phase_reg;
        slot_next        = slot_reg;
        slot_valid_next  = slot_valid_reg;
        total_next       = total_reg;
        start_stamp_next = start_stamp_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        in_next          = in_reg;
        out_next         = out_reg;
        stored_next      = stored_reg;
        hit_next         = hit_reg;
        found_next       = found_reg;
        rtime_next       = rtime_reg;
        rvalue_next      = rvalue_reg;
        stamp_next       = stamp_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;
        pend_next        = pend_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        step_next        = step_reg;

        if (cfg_we) begin
            case (cfg_index)
                psrr_pkg::CFG_PERIOD:    period_next = cfg_wdata[PW-1:0];
                psrr_pkg::CFG_MODE:      mode_next   = cfg_wdata[psrr_pkg::MODE_W-1:0];
                psrr_pkg::CFG_THRESHOLD: thresh_next = $signed(cfg_wdata[VW-1:0]);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next     = s_data;
                    hit_next    = ev_hit;
                    stored_next = 1'b0;
                    found_next  = 1'b0;
                    rvalue_next = '0;
                    rtime_next  = '0;
                    issue_next  = '0;
                    pend_next   = 1'b0;
                    count_next  = (total_reg >= 32'(RING_DEPTH)) ? CW'(RING_DEPTH)
                                                                : total_reg[CW-1:0];
                    state_next  = S_DONE;
                    case (s_data.opcode)
                        psrr_pkg::OP_START: begin
                            recording_next = 1'b1;
                            phase_next     = '0;
                            if (total_reg == '0) begin
                                start_stamp_next = s_data.start_time;
                                slot_valid_next  = 1'b0;
                            end
                            state_next = S_TICK;
                        end
                        psrr_pkg::OP_STOP: begin
                            recording_next = 1'b0;
                        end
                        psrr_pkg::OP_TICK: begin
                            if (recording_reg) begin
                                state_next = S_TICK;
                            end
                        end
                        psrr_pkg::OP_LOOKUP, psrr_pkg::OP_NEXT: begin
                            rtime_next = '1;
                            state_next = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_TICK: begin
                if (phase_reg != '0) begin
                    state_next = S_PHASE;
                end else if (slot_valid_reg) begin
                    state_next = S_TREAD;
                end else begin
                    stamp_next      = start_stamp_reg + TW'(1);
                    slot_next       = '0;
                    slot_valid_next = 1'b1;
                    state_next      = S_TWRITE;
                end
            end
            S_TREAD: begin
                stamp_next = stamp_rdata + TW'(eff_period);
                slot_next  = (slot_reg == AW'(RING_DEPTH - 1)) ? '0 : slot_reg + AW'(1);
                state_next = S_TWRITE;
            end
            S_TWRITE: begin
                stored_next = 1'b1;
                if (total_reg != '1) begin
                    total_next = total_reg + 32'd1;
                end
                state_next = S_PHASE;
            end
            S_PHASE: begin
                if (phase_sum < {1'b0, eff_period}) begin
                    phase_next = phase_sum[PW-1:0];
                    state_next = S_DONE;
                end else if (phase_sum == {1'b0, eff_period}) begin
                    phase_next = '0;
                    state_next = S_DONE;
                end else begin
                    rem_next   = '0;
                    dvd_next   = phase_sum;
                    step_next  = MCW'(MOD_STEPS);
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                rem_next  = trial_sub[PW] ? trial[PW-1:0] : trial_sub[PW-1:0];
                dvd_next  = {dvd_reg[PW-1:0], 1'b0};
                step_next = step_reg - MCW'(1);
                if (step_reg == MCW'(1)) begin
                    phase_next = rem_next;
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                pend_next = issue_ok;
                if (issue_ok) begin
                    issue_next = issue_reg + CW'(1);
                end
                if (pend_reg) begin
                    if (in_reg.opcode == psrr_pkg::OP_LOOKUP) begin
                        if (stamp_rdata == in_reg.query_time) begin
                            found_next  = 1'b1;
                            rtime_next  = stamp_rdata;
                            rvalue_next = $signed(value_rdata);
                            state_next  = S_DONE;
                        end
                    end else if (stamp_rdata > in_reg.query_time && stamp_rdata < rtime_reg) begin
                        rtime_next = stamp_rdata;
                    end
                end else if (!issue_ok) begin
                    if (in_reg.opcode == psrr_pkg::OP_NEXT) begin
                        found_next = rtime_reg != '1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.sample_stored = stored_reg;
                    out_next.event_hit     = hit_reg;
                    out_next.found         = found_reg;
                    out_next.result_time   = rtime_reg;
                    out_next.result_value  = rvalue_reg;
                    m_valid_next           = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            period_reg      <= PW'(1);
            mode_reg        <= psrr_pkg::EV_NONE;
            thresh_reg      <= '0;
            recording_reg   <= 1'b0;
            phase_reg       <= '0;
            slot_reg        <= '0;
            slot_valid_reg  <= 1'b0;
            total_reg       <= '0;
            start_stamp_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            period_reg      <= period_next;
            mode_reg        <= mode_next;
            thresh_reg      <= thresh_next;
            recording_reg   <= recording_next;
            phase_reg       <= phase_next;
            slot_reg        <= slot_next;
            slot_valid_reg  <= slot_valid_next;
            total_reg       <= total_next;
            start_stamp_reg <= start_stamp_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        out_reg    <= out_next;
        stored_reg <= stored_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        rtime_reg  <= rtime_next;
        rvalue_reg <= rvalue_next;
        stamp_reg  <= stamp_next;
        count_reg  <= count_next;
        issue_reg  <= issue_next;
        pend_reg   <= pend_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        step_reg   <= step_next;
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/psrr_checker.sv =====
// Port-level assertions for the periodic sample ring recorder, with its bind.
// Depends on psrr_pkg; attaches to periodic_sample_ring_recorder.
`default_nettype none

module psrr_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire psrr_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire psrr_pkg::out_item_t m_data
);

    // A stalled result item must hold its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // The block works on one item at a time, so it is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous item in progress");

    // An item that stored a sample carries no query time.
    a_store_no_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sample_stored |-> m_data.result_time == '0)
        else $error("result time on an item that stored a sample");

    // Queries never store, and a value is only returned with a match.
    a_found_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> !m_data.sample_stored)
        else $error("found and sample_stored in one item");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.result_value == '0)
        else $error("result value without a match");

endmodule

bind periodic_sample_ring_recorder psrr_checker u_psrr_checker (.*);

`default_nettype wire
